>>> src/smfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfp_pkg
// Shared result kinds, result layout and widths for the MIDI file parser.
// ----------------------------------------------------------------------------
package smfp_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int DATA_W = 144;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TRACK   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CHANNEL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TEMPO   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TIMESIG = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd5;

    // payload, last member in the lowest bits
    typedef struct packed {
        logic [15:0] time_division;
        logic [15:0] track_total;
        logic [15:0] file_format;
        logic [7:0]  ts_denom_log2;
        logic [7:0]  ts_numerator;
        logic [23:0] tempo_us;
        logic [7:0]  data_two;
        logic [7:0]  data_one;
        logic [7:0]  status_byte;
        logic [31:0] abs_time;
    } smfp_payload_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        smfp_payload_t     payload;
    } smfp_result_t;

endpackage

>>> src/smfp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfp_in_reg
// Input register holding one file byte until the parser consumes it.
// ----------------------------------------------------------------------------
module smfp_in_reg
    import smfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data,
    input  logic              advance,
    output logic              q_valid,
    output logic [BYTE_W-1:0] q_data
);

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    assign s_ready = !valid_reg || advance;
    assign q_valid = valid_reg;
    assign q_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

>>> src/smfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfp_parser
// Parser state and the per-byte next-state and result decode.
// ----------------------------------------------------------------------------
module smfp_parser
    import smfp_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              res_valid,
    output smfp_result_t      res,
    output logic              halted
);

    localparam logic [4:0] PH_TAG   = 5'd0;
    localparam logic [4:0] PH_LEN   = 5'd1;
    localparam logic [4:0] PH_HDR   = 5'd2;
    localparam logic [4:0] PH_SKIP  = 5'd3;
    localparam logic [4:0] PH_DELTA = 5'd4;
    localparam logic [4:0] PH_EVENT = 5'd5;
    localparam logic [4:0] PH_DATA1 = 5'd6;
    localparam logic [4:0] PH_DATA2 = 5'd7;
    localparam logic [4:0] PH_MTYPE = 5'd8;
    localparam logic [4:0] PH_MLEN  = 5'd9;
    localparam logic [4:0] PH_MDATA = 5'd10;
    localparam logic [4:0] PH_SYSEX = 5'd11;

    localparam logic [31:0] TAG_HEADER   = 32'h4D546864;
    localparam logic [31:0] TAG_TRACK    = 32'h4D54726B;
    localparam logic [7:0]  STATUS_META  = 8'hFF;
    localparam logic [7:0]  STATUS_SYS   = 8'hF0;
    localparam logic [7:0]  SYSEX_END    = 8'hF7;
    localparam logic [7:0]  META_TEMPO   = 8'h51;
    localparam logic [7:0]  META_TIMESIG = 8'h58;

    function automatic logic [1:0] needed_for(input logic [7:0] status);
        logic [3:0] hi;
        hi = status[7:4];
        return (hi == 4'hC || hi == 4'hD) ? 2'd1 : 2'd2;
    endfunction

    logic [4:0]            phase_reg,     phase_next;
    logic [31:0]           tag_reg,       tag_next;
    logic [31:0]           rem_reg,       rem_next;
    logic                  is_track_reg,  is_track_next;
    logic [2:0]            idx_reg,       idx_next;
    logic [TIME_WIDTH-1:0] delta_reg,     delta_next;
    logic [TIME_WIDTH-1:0] time_reg,      time_next;
    logic [7:0]            run_reg,       run_next;
    logic [1:0]            needed_reg,    needed_next;
    logic [7:0]            first_reg,     first_next;
    logic [7:0]            mtype_reg,     mtype_next;
    logic [7:0]            mleft_reg,     mleft_next;
    logic [47:0]           field_reg,     field_next;
    logic                  halted_reg,    halted_next;

    logic                  in_chunk;
    logic [3:0]            idx_inc;
    logic [2:0]            idx_meta;
    logic [31:0]           rem_dec;
    logic [TIME_WIDTH-1:0] delta_shift;
    logic [63:0]           time_wide;
    logic [31:0]           time_abs;

    assign idx_inc     = {1'b0, idx_reg} + 4'd1;
    assign idx_meta    = (idx_reg < 3'd7) ? idx_inc[2:0] : idx_reg;
    assign rem_dec     = rem_reg - 32'd1;
    assign delta_shift = {delta_reg[TIME_WIDTH-8:0], in_byte[6:0]};
    assign time_wide   = 64'(time_reg);
    assign time_abs    = time_wide[31:0];
    assign halted      = halted_reg;

    always_comb begin
        phase_next    = phase_reg;
        tag_next      = tag_reg;
        rem_next      = rem_reg;
        is_track_next = is_track_reg;
        idx_next      = idx_reg;
        delta_next    = delta_reg;
        time_next     = time_reg;
        run_next      = run_reg;
        needed_next   = needed_reg;
        first_next    = first_reg;
        mtype_next    = mtype_reg;
        mleft_next    = mleft_reg;
        field_next    = field_reg;
        halted_next   = halted_reg;
        res           = '0;
        res_valid     = 1'b0;
        in_chunk      = 1'b0;

        if (step && !halted_reg) begin
            in_chunk = 1'b1;
            unique case (phase_reg)
                PH_TAG: begin
                    in_chunk = 1'b0;
                    tag_next = {tag_reg[23:0], in_byte};
                    idx_next = idx_inc[2:0];
                    if (idx_inc >= 4'd4) begin
                        idx_next = 3'd0;
                        rem_next = 32'd0;
                        if (tag_next == TAG_HEADER) begin
                            is_track_next = 1'b0;
                            phase_next    = PH_LEN;
                        end else if (tag_next == TAG_TRACK) begin
                            is_track_next = 1'b1;
                            phase_next    = PH_LEN;
                        end else begin
                            res.kind    = KIND_ERROR;
                            res_valid   = 1'b1;
                            halted_next = 1'b1;
                        end
                    end
                end
                PH_LEN: begin
                    in_chunk = 1'b0;
                    rem_next = {rem_reg[23:0], in_byte};
                    idx_next = idx_inc[2:0];
                    if (idx_inc >= 4'd4) begin
                        idx_next   = 3'd0;
                        field_next = '0;
                        if (is_track_reg) begin
                            res.kind   = KIND_TRACK;
                            res_valid  = 1'b1;
                            time_next  = '0;
                            delta_next = '0;
                            run_next   = 8'd0;
                            phase_next = PH_DELTA;
                        end else begin
                            phase_next = PH_HDR;
                        end
                        // zero-length chunk goes straight back to tag framing
                        if (rem_next == 32'd0) begin
                            phase_next = PH_TAG;
                            tag_next   = 32'd0;
                        end
                    end
                end
                PH_HDR: begin
                    field_next = {field_reg[39:0], in_byte};
                    idx_next   = idx_inc[2:0];
                    if (idx_inc >= 4'd6) begin
                        res.kind                  = KIND_HEADER;
                        res.payload.file_format   = field_next[47:32];
                        res.payload.track_total   = field_next[31:16];
                        res.payload.time_division = field_next[15:0];
                        res_valid                 = 1'b1;
                        phase_next                = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                end
                PH_DELTA: begin
                    if (!in_byte[7]) begin
                        time_next  = time_reg + delta_shift;
                        delta_next = '0;
                        phase_next = PH_EVENT;
                    end else begin
                        delta_next = delta_shift;
                    end
                end
                PH_EVENT: begin
                    if (in_byte[7]) begin
                        if (in_byte == STATUS_META) begin
                            run_next   = 8'd0;
                            phase_next = PH_MTYPE;
                        end else if (in_byte >= STATUS_SYS) begin
                            run_next   = 8'd0;
                            phase_next = (in_byte == SYSEX_END) ? PH_DELTA : PH_SYSEX;
                        end else begin
                            run_next    = in_byte;
                            needed_next = needed_for(in_byte);
                            phase_next  = PH_DATA1;
                        end
                    end else if (run_reg == 8'd0) begin
                        // stray data byte, no running status
                        phase_next = PH_DELTA;
                    end else begin
                        needed_next = needed_for(run_reg);
                        if (needed_next == 2'd1) begin
                            res.kind                = KIND_CHANNEL;
                            res.payload.abs_time    = time_abs;
                            res.payload.status_byte = run_reg;
                            res.payload.data_one    = in_byte;
                            res_valid               = 1'b1;
                            phase_next              = PH_DELTA;
                        end else begin
                            first_next = in_byte;
                            phase_next = PH_DATA2;
                        end
                    end
                end
                PH_DATA1: begin
                    if (needed_reg == 2'd1) begin
                        res.kind                = KIND_CHANNEL;
                        res.payload.abs_time    = time_abs;
                        res.payload.status_byte = run_reg;
                        res.payload.data_one    = in_byte;
                        res_valid               = 1'b1;
                        phase_next              = PH_DELTA;
                    end else begin
                        first_next = in_byte;
                        phase_next = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    res.kind                = KIND_CHANNEL;
                    res.payload.abs_time    = time_abs;
                    res.payload.status_byte = run_reg;
                    res.payload.data_one    = first_reg;
                    res.payload.data_two    = in_byte;
                    res_valid               = 1'b1;
                    phase_next              = PH_DELTA;
                end
                PH_MTYPE: begin
                    mtype_next = in_byte;
                    phase_next = PH_MLEN;
                end
                PH_MLEN: begin
                    mleft_next = in_byte;
                    idx_next   = 3'd0;
                    field_next = '0;
                    phase_next = (in_byte == 8'd0) ? PH_DELTA : PH_MDATA;
                end
                PH_MDATA: begin
                    field_next = {field_reg[39:0], in_byte};
                    idx_next   = idx_meta;
                    if (mtype_reg == META_TEMPO && idx_meta == 3'd3) begin
                        res.kind             = KIND_TEMPO;
                        res.payload.abs_time = time_abs;
                        res.payload.tempo_us = field_next[23:0];
                        res_valid            = 1'b1;
                    end else if (mtype_reg == META_TIMESIG && idx_meta == 3'd2) begin
                        res.kind                  = KIND_TIMESIG;
                        res.payload.abs_time      = time_abs;
                        res.payload.ts_numerator  = field_next[15:8];
                        res.payload.ts_denom_log2 = field_next[7:0];
                        res_valid                 = 1'b1;
                    end
                    mleft_next = mleft_reg - 8'd1;
                    if (mleft_next == 8'd0) begin
                        idx_next   = 3'd0;
                        phase_next = PH_DELTA;
                    end
                end
                PH_SYSEX: begin
                    if (in_byte == SYSEX_END) begin
                        phase_next = PH_DELTA;
                    end
                end
                default: begin
                    phase_next = PH_TAG;
                    tag_next   = 32'd0;
                    idx_next   = 3'd0;
                    in_chunk   = 1'b0;
                end
            endcase

            // chunk byte count; running out drops any partial event
            if (in_chunk) begin
                rem_next = rem_dec;
                if (rem_dec == 32'd0) begin
                    phase_next = PH_TAG;
                    tag_next   = 32'd0;
                    idx_next   = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TAG;
            tag_reg      <= 32'd0;
            rem_reg      <= 32'd0;
            is_track_reg <= 1'b0;
            idx_reg      <= 3'd0;
            delta_reg    <= '0;
            time_reg     <= '0;
            run_reg      <= 8'd0;
            needed_reg   <= 2'd0;
            first_reg    <= 8'd0;
            mtype_reg    <= 8'd0;
            mleft_reg    <= 8'd0;
            field_reg    <= 48'd0;
            halted_reg   <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            tag_reg      <= tag_next;
            rem_reg      <= rem_next;
            is_track_reg <= is_track_next;
            idx_reg      <= idx_next;
            delta_reg    <= delta_next;
            time_reg     <= time_next;
            run_reg      <= run_next;
            needed_reg   <= needed_next;
            first_reg    <= first_next;
            mtype_reg    <= mtype_next;
            mleft_reg    <= mleft_next;
            field_reg    <= field_next;
            halted_reg   <= halted_next;
        end
    end

endmodule

>>> src/smfp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfp_out_reg
// Result register driving the output stream.
// ----------------------------------------------------------------------------
module smfp_out_reg
    import smfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              res_valid,
    input  smfp_result_t      res,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0] m_tuser
);

    logic         valid_reg;
    smfp_result_t res_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.payload;
    assign m_tuser  = res_reg.kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= res_valid;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

>>> src/midi_file_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_file_stream_parser_top
// Standard MIDI file parser: file bytes in, header/track/event items out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes the raw file one byte per item (s_tdata). The parser
//   frames chunks by tag and length, decodes the header chunk and the track
//   events (delta times, running status, tempo and time signature metas).
//   m_ channel gives at most one item per input byte; m_tuser carries the
//   kind (header, track start, channel event, tempo, time sig, error) and
//   m_tdata the payload, unused fields zero.
//   Throughput: one byte per cycle, sustained while m_tready is high. Each
//   byte passes an input register, the combinational parser decode, and
//   the result register, which drives m_tvalid.
//   A byte that produces nothing still moves on only when the result slot
//   is free, so it waits behind a held result like any other byte.
//   Stall: when m_tready is low with a result held, the input register
//   fills and s_tready drops; nothing is lost or repeated.
//   Reset (aresetn low, synchronous): parser goes back to tag framing with
//   all state cleared. An unknown chunk tag emits an error item and the
//   parser then ignores every byte until the next reset.
// ----------------------------------------------------------------------------
module midi_file_stream_parser_top
    import smfp_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // file_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    // abs_time, status_byte, data_one, data_two, tempo_us, ts_numerator,
    // ts_denom_log2, file_format, track_total, time_division
    output logic [DATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0] m_tuser    // kind
);

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              out_free;
    logic              advance;
    logic              res_valid;
    smfp_result_t      res;
    logic              halted;

    // a held byte moves on whenever the result slot can take it
    assign advance = in_valid && out_free;

    smfp_in_reg u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_data  (s_tdata),
        .advance (advance),
        .q_valid (in_valid),
        .q_data  (in_byte)
    );

    smfp_parser #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res),
        .halted    (halted)
    );

    smfp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // error item only ever comes with the parser locked up
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_ERROR) |-> halted)
        else $error("error item without halt");

    // halt is sticky until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        halted |=> halted)
        else $error("halt released without reset");

    // non-channel items carry no status byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_CHANNEL) |-> (m_tdata[39:32] == 8'd0))
        else $error("status byte on non-channel item");

    // header and track start items have zero time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_HEADER || m_tuser == KIND_TRACK))
        |-> (m_tdata[31:0] == 32'd0))
        else $error("time on header or track start");

endmodule

>>> dv/smf_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_event_checker
// Watches both channels of the MIDI file parser, predicts each item and
// compares it field by field with what the parser returns.
// ----------------------------------------------------------------------------
package smf_codes_pkg;

    localparam logic [31:0] ID_MTHD = 32'h4D546864;
    localparam logic [31:0] ID_MTRK = 32'h4D54726B;

    localparam logic [7:0] META_ESC     = 8'hFF;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_TIMESIG = 8'h58;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_END    = 8'hF7;

    localparam logic [7:0] NOTE_ON     = 8'h90;
    localparam logic [7:0] CTRL_CHANGE = 8'hB0;
    localparam logic [7:0] PROG_CHANGE = 8'hC0;
    localparam logic [7:0] PITCH_BEND  = 8'hE0;

endpackage

module smf_event_checker
    import smfp_pkg::*;
    import smf_codes_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,
    input  logic [KIND_W-1:0] m_tuser,
    output int                fail_count,
    output int                pending,
    output int                items_checked
);

    typedef enum logic [3:0] {
        P_CHUNK_ID, P_CHUNK_LEN, P_HEADER, P_SKIP, P_DELTA, P_EVENT,
        P_DATA_A, P_DATA_B, P_META_TYPE, P_META_LEN, P_META_BODY, P_SYSEX
    } parse_phase_e;

    // parser shadow state
    parse_phase_e phase;
    logic [31:0]  id_shift;
    logic [31:0]  chunk_left;
    logic [31:0]  delta_sum;
    logic [31:0]  now_ticks;
    logic [47:0]  field_sr;
    logic [2:0]   idx;
    logic [7:0]   run_status;
    logic [7:0]   ch_first;
    logic [7:0]   meta_kind;
    logic [7:0]   meta_count;
    logic [1:0]   data_cnt;
    bit           in_track;
    bit           dead;

    smfp_result_t items_due[$];

    function automatic logic [1:0] data_bytes_for(input logic [7:0] status);
        return (status[7:4] == 4'hC || status[7:4] == 4'hD) ? 2'd1 : 2'd2;
    endfunction

    function automatic smfp_result_t channel_item(input logic [7:0] d1, input logic [7:0] d2);
        smfp_result_t r;
        r = '0;
        r.kind                = KIND_CHANNEL;
        r.payload.abs_time    = now_ticks;
        r.payload.status_byte = run_status;
        r.payload.data_one    = d1;
        r.payload.data_two    = d2;
        return r;
    endfunction

    task automatic clear_parser();
        phase      = P_CHUNK_ID;
        id_shift   = '0;
        chunk_left = '0;
        delta_sum  = '0;
        now_ticks  = '0;
        field_sr   = '0;
        idx        = '0;
        run_status = '0;
        ch_first   = '0;
        meta_kind  = '0;
        meta_count = '0;
        data_cnt   = '0;
        in_track   = 1'b0;
        dead       = 1'b0;
    endtask

    // advance the shadow parser by one file byte, queue any item it makes
    task automatic decode_byte(input logic [7:0] b);
        smfp_result_t r;
        bit           emit;
        bit           in_body;
        r    = '0;
        emit = 1'b0;
        if (dead) return;
        in_body = (phase != P_CHUNK_ID) && (phase != P_CHUNK_LEN);
        case (phase)
            P_CHUNK_ID: begin
                id_shift = {id_shift[23:0], b};
                idx      = idx + 1'b1;
                if (idx >= 3'd4) begin
                    idx        = '0;
                    chunk_left = '0;
                    if (id_shift == ID_MTHD) begin
                        in_track = 1'b0;
                        phase    = P_CHUNK_LEN;
                    end else if (id_shift == ID_MTRK) begin
                        in_track = 1'b1;
                        phase    = P_CHUNK_LEN;
                    end else begin
                        r.kind = KIND_ERROR;
                        emit   = 1'b1;
                        dead   = 1'b1;
                    end
                end
            end
            P_CHUNK_LEN: begin
                chunk_left = {chunk_left[23:0], b};
                idx        = idx + 1'b1;
                if (idx >= 3'd4) begin
                    idx      = '0;
                    field_sr = '0;
                    if (in_track) begin
                        r.kind     = KIND_TRACK;
                        emit       = 1'b1;
                        now_ticks  = '0;
                        delta_sum  = '0;
                        run_status = '0;
                        phase      = P_DELTA;
                    end else begin
                        phase = P_HEADER;
                    end
                    if (chunk_left == 0) begin
                        phase    = P_CHUNK_ID;
                        id_shift = '0;
                    end
                end
            end
            P_HEADER: begin
                field_sr = {field_sr[39:0], b};
                idx      = idx + 1'b1;
                if (idx >= 3'd6) begin
                    r.kind                  = KIND_HEADER;
                    r.payload.file_format   = field_sr[47:32];
                    r.payload.track_total   = field_sr[31:16];
                    r.payload.time_division = field_sr[15:0];
                    emit  = 1'b1;
                    phase = P_SKIP;
                end
            end
            P_SKIP: ;
            P_DELTA: begin
                delta_sum = (delta_sum << 7) + {25'd0, b[6:0]};
                if (!b[7]) begin
                    now_ticks = now_ticks + delta_sum;
                    delta_sum = '0;
                    phase     = P_EVENT;
                end
            end
            P_EVENT: begin
                if (b[7]) begin
                    if (b == META_ESC) begin
                        run_status = '0;
                        phase      = P_META_TYPE;
                    end else if (b >= SYSEX_START) begin
                        run_status = '0;
                        phase      = (b == SYSEX_END) ? P_DELTA : P_SYSEX;
                    end else begin
                        run_status = b;
                        data_cnt   = data_bytes_for(b);
                        phase      = P_DATA_A;
                    end
                end else if (run_status == 8'h00) begin
                    // stray data byte, no status to run on
                    phase = P_DELTA;
                end else begin
                    data_cnt = data_bytes_for(run_status);
                    if (data_cnt == 2'd1) begin
                        r     = channel_item(b, 8'h00);
                        emit  = 1'b1;
                        phase = P_DELTA;
                    end else begin
                        ch_first = b;
                        phase    = P_DATA_B;
                    end
                end
            end
            P_DATA_A: begin
                if (data_cnt == 2'd1) begin
                    r     = channel_item(b, 8'h00);
                    emit  = 1'b1;
                    phase = P_DELTA;
                end else begin
                    ch_first = b;
                    phase    = P_DATA_B;
                end
            end
            P_DATA_B: begin
                r     = channel_item(ch_first, b);
                emit  = 1'b1;
                phase = P_DELTA;
            end
            P_META_TYPE: begin
                meta_kind = b;
                phase     = P_META_LEN;
            end
            P_META_LEN: begin
                meta_count = b;
                idx        = '0;
                field_sr   = '0;
                phase      = (b == 8'h00) ? P_DELTA : P_META_BODY;
            end
            P_META_BODY: begin
                field_sr = {field_sr[39:0], b};
                if (idx < 3'd7) idx = idx + 1'b1;
                if (meta_kind == META_TEMPO && idx == 3'd3) begin
                    r.kind             = KIND_TEMPO;
                    r.payload.abs_time = now_ticks;
                    r.payload.tempo_us = field_sr[23:0];
                    emit               = 1'b1;
                end else if (meta_kind == META_TIMESIG && idx == 3'd2) begin
                    r.kind                  = KIND_TIMESIG;
                    r.payload.abs_time      = now_ticks;
                    r.payload.ts_numerator  = field_sr[15:8];
                    r.payload.ts_denom_log2 = field_sr[7:0];
                    emit                    = 1'b1;
                end
                meta_count = meta_count - 1'b1;
                if (meta_count == 8'h00) begin
                    idx   = '0;
                    phase = P_DELTA;
                end
            end
            P_SYSEX: begin
                if (b == SYSEX_END) phase = P_DELTA;
            end
            default: begin
                phase    = P_CHUNK_ID;
                id_shift = '0;
                idx      = '0;
                in_body  = 1'b0;
            end
        endcase

        // chunk byte count runs out: back to id framing, partial work dropped
        if (in_body) begin
            chunk_left = chunk_left - 1'b1;
            if (chunk_left == 0) begin
                phase    = P_CHUNK_ID;
                id_shift = '0;
                idx      = '0;
            end
        end
        if (emit) items_due.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_item(input smfp_result_t got);
        smfp_result_t want;
        if (items_due.size() == 0) begin
            $error("unexpected item, kind %0d", got.kind);
            fail_count++;
            return;
        end
        want = items_due.pop_front();
        items_checked++;
        check_field("kind", 32'(want.kind), 32'(got.kind));
        check_field("abs_time", want.payload.abs_time, got.payload.abs_time);
        check_field("status_byte", 32'(want.payload.status_byte),
                    32'(got.payload.status_byte));
        check_field("data_one", 32'(want.payload.data_one), 32'(got.payload.data_one));
        check_field("data_two", 32'(want.payload.data_two), 32'(got.payload.data_two));
        check_field("tempo_us", 32'(want.payload.tempo_us), 32'(got.payload.tempo_us));
        check_field("ts_numerator", 32'(want.payload.ts_numerator),
                    32'(got.payload.ts_numerator));
        check_field("ts_denom_log2", 32'(want.payload.ts_denom_log2),
                    32'(got.payload.ts_denom_log2));
        check_field("file_format", 32'(want.payload.file_format),
                    32'(got.payload.file_format));
        check_field("track_total", 32'(want.payload.track_total),
                    32'(got.payload.track_total));
        check_field("time_division", 32'(want.payload.time_division),
                    32'(got.payload.time_division));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            items_due.delete();
            fail_count    = 0;
            items_checked = 0;
        end else begin
            if (s_tvalid && s_tready) decode_byte(s_tdata);
            if (m_tvalid && m_tready) compare_item({m_tuser, m_tdata});
        end
        pending = items_due.size();
    end

endmodule

>>> dv/tb_midi_file_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_file_stream_parser_top
// Feeds the MIDI file parser a stream of generated chunks: a short directed
// file, then random header and track chunks (mostly well formed, some cut
// short or padded), and finally an unknown chunk id that halts the parser.
// Both channels idle at random; a checker beside the block predicts and
// compares every item.
// ----------------------------------------------------------------------------
module tb_midi_file_stream_parser_top;
    import smfp_pkg::*;
    import smf_codes_pkg::*;

    localparam int unsigned RANDOM_BYTES = 620;
    localparam int unsigned FLOOD_HOLD   = 300;     // long m_tready hold-off
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // directed track: each event kind, running status both widths, a stray
    // data byte after a meta, a delta that wraps the 32-bit time, a short
    // tempo, an empty meta, and a control change cut off by the chunk end
    localparam int DEMO_LEN = 62;
    localparam logic [7:0] DEMO_TRACK [0:DEMO_LEN-1] = '{
        8'h00, NOTE_ON, 8'h3C, 8'h7F,
        8'h00, 8'h3C, 8'h00,
        8'h81, 8'h00, PROG_CHANGE | 8'h05, 8'hFF,
        8'h00, 8'h40,
        8'h00, META_ESC, META_TEMPO, 8'h03, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'h40,
        8'h00, META_ESC, META_TIMESIG, 8'h04, 8'h04, 8'h02, 8'h18, 8'h08,
        8'h00, SYSEX_START, 8'h01, 8'h02, SYSEX_END,
        8'h00, SYSEX_END,
        8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, PITCH_BEND | 8'h03, 8'h00, 8'h40,
        8'h00, NOTE_ON, 8'h00, 8'h00,
        8'h00, META_ESC, META_TEMPO, 8'h02, 8'h01, 8'h02,
        8'h00, META_ESC, META_TEMPO, 8'h00,
        8'h00, CTRL_CHANGE, 8'h07
    };

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;     // file_byte
    logic              m_tvalid;
    logic              m_tready;
    // abs_time, status_byte, data_one, data_two, tempo_us, ts_numerator,
    // ts_denom_log2, file_format, track_total, time_division
    logic [DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0] m_tuser;     // kind

    int fail_count;
    int pending;
    int items_checked;

    // stimulus bookkeeping
    logic [7:0]  body_q[$];          // chunk payload being built
    logic [7:0]  tx_q[$];            // framed bytes waiting to go out
    logic [7:0]  gen_status;         // running status the generator assumes
    int unsigned bytes_sent;
    int unsigned header_chunks;
    int unsigned track_chunks;
    int unsigned cycle_count;
    bit          flood_on;
    bit          flood_done;

    midi_file_stream_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    smf_event_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .items_checked (items_checked)
    );

    // 20 ns clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // watchdog: a hung handshake ends the run as a failure
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // idle length: mostly short, now and then a long gap
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // chunk builders
    // ------------------------------------------------------------------------
    function automatic void put(input int unsigned v);
        body_q.push_back(v[7:0]);
    endfunction

    // data byte: mostly 7-bit, sometimes full range
    function automatic void put_data();
        if ($urandom_range(0, 99) < 88) put($urandom_range(0, 127));
        else put($urandom_range(0, 255));
    endfunction

    // id, big-endian length, then len payload bytes; a length past the
    // payload is filled with random bytes, a shorter one cuts it off
    function automatic void add_chunk(input logic [31:0] id, input int unsigned len);
        logic [31:0] len_w;
        len_w = len;
        for (int i = 3; i >= 0; i--) tx_q.push_back(id[8*i +: 8]);
        for (int i = 3; i >= 0; i--) tx_q.push_back(len_w[8*i +: 8]);
        for (int unsigned i = 0; i < len; i++) begin
            if (i < body_q.size()) tx_q.push_back(body_q[i]);
            else tx_q.push_back(8'($urandom_range(0, 255)));
        end
        body_q.delete();
        if (id == ID_MTHD) header_chunks++;
        else if (id == ID_MTRK) track_chunks++;
    endfunction

    // delta time: zero, one byte, a few bytes, or a long run that wraps
    function automatic void add_delta();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            put(0);
            return;
        end
        if (pick < 75) n = 0;
        else if (pick < 93) n = $urandom_range(1, 3);
        else n = $urandom_range(4, 7);
        repeat (n) put($urandom_range(128, 255));
        put($urandom_range(0, 127));
    endfunction

    function automatic void add_meta(input logic [7:0] mtype, input int unsigned len);
        int unsigned pick;
        put(META_ESC);
        put(mtype);
        put(len);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) put(8'h00);
            else if (pick < 30) put(8'hFF);
            else put($urandom_range(0, 255));
        end
        gen_status = 8'h00;
    endfunction

    function automatic void add_event();
        int unsigned pick;
        logic [7:0]  s;
        pick = $urandom_range(0, 99);
        add_delta();
        if (pick < 40) begin
            s = 8'($urandom_range(8'h80, 8'hEF));
            put(s);
            put_data();
            if (s[7:4] != 4'hC && s[7:4] != 4'hD) put_data();
            gen_status = s;
        end else if (pick < 58) begin
            // running status data; a stray byte if no status is active
            put($urandom_range(0, 127));
            if (gen_status != 8'h00 && gen_status[7:4] != 4'hC && gen_status[7:4] != 4'hD)
                put_data();
        end else if (pick < 68) begin
            add_meta(META_TEMPO, ($urandom_range(0, 99) < 88) ? 3 : $urandom_range(0, 6));
        end else if (pick < 76) begin
            add_meta(META_TIMESIG, ($urandom_range(0, 99) < 88) ? 4 : $urandom_range(0, 6));
        end else if (pick < 84) begin
            add_meta(8'($urandom_range(0, 255)),
                     ($urandom_range(0, 99) < 95) ? $urandom_range(0, 5)
                                                   : $urandom_range(0, 255));
        end else if (pick < 96) begin
            // sysex, or another system status, run up to the closing byte
            if (pick < 91) begin
                s = SYSEX_START;
            end else begin
                s = 8'($urandom_range(8'hF1, 8'hFE));
                if (s == SYSEX_END) s = SYSEX_START;
            end
            put(s);
            repeat ($urandom_range(0, 5)) put($urandom_range(0, 127));
            put(SYSEX_END);
            gen_status = 8'h00;
        end else begin
            put(SYSEX_END);
            gen_status = 8'h00;
        end
    endfunction

    function automatic void add_random_track(input int unsigned n_events, input bit exact_len);
        int unsigned pick;
        int unsigned len;
        gen_status = 8'h00;
        repeat (n_events) add_event();
        len  = body_q.size();
        pick = $urandom_range(0, 99);
        if (!exact_len) begin
            if (pick < 78) len = body_q.size();
            else if (pick < 88) len = (len > 1) ? $urandom_range(1, len - 1) : len;
            else if (pick < 94) len = len + $urandom_range(1, 6);
            else len = 0;
        end
        add_chunk(ID_MTRK, len);
    endfunction

    function automatic void add_random_header();
        int unsigned pick;
        int unsigned len;
        repeat (3) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                put(8'h00); put(8'h00);
            end else if (pick < 40) begin
                put(8'hFF); put(8'hFF);
            end else begin
                put($urandom_range(0, 255)); put($urandom_range(0, 255));
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) len = 6;
        else if (pick < 85) len = $urandom_range(7, 12);   // extra bytes skipped
        else len = $urandom_range(0, 5);                   // too short, no item
        add_chunk(ID_MTHD, len);
    endfunction

    // ------------------------------------------------------------------------
    // s_ side driver: data changes on the falling edge, handshake is seen on
    // the rising edge
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input int unsigned gap);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic play_chunks(input bit gappy);
        logic [7:0]  b;
        int unsigned gap;
        while (tx_q.size() > 0) begin
            b   = tx_q.pop_front();
            gap = (gappy && $urandom_range(0, 99) < 35) ? idle_len() : 0;
            send_byte(b, gap);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // hold the sender until the checker has nothing outstanding
    task automatic wait_drained();
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // m_ side: random back-pressure, calm stretches, one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int unsigned hold_left;
        int unsigned calm_left;
        hold_left = 0;
        calm_left = 0;
        m_tready  = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (flood_on && !flood_done) begin
                m_tready <= 1'b0;
                repeat (FLOOD_HOLD) @(negedge aclk);
                m_tready <= 1'b1;
                flood_done = 1'b1;
            end else if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= 1'b1;
                if (calm_left > 0) calm_left--;
                else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(100, 300);
                else if ($urandom_range(0, 99) < 30) hold_left = idle_len();
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] bad_id;
        int unsigned random_start;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        flood_on      = 1'b0;
        flood_done    = 1'b0;
        bytes_sent    = 0;
        header_chunks = 0;
        track_chunks  = 0;
        gen_status    = 8'h00;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: header at its extremes with two extra bytes, an empty
        // track, the demo track, then a header too short to report
        put(8'hFF); put(8'hFF); put(8'h00); put(8'h00);
        put(8'hFF); put(8'hFF); put(8'h5A); put(8'hA5);
        add_chunk(ID_MTHD, 8);
        add_chunk(ID_MTRK, 0);
        foreach (DEMO_TRACK[i]) body_q.push_back(DEMO_TRACK[i]);
        add_chunk(ID_MTRK, DEMO_LEN);
        put(8'h00); put(8'h01); put(8'h00);
        add_chunk(ID_MTHD, 3);
        play_chunks(1'b1);
        wait_drained();

        // a long track sent back to back while the m_ side holds off
        random_start = bytes_sent;
        flood_on = 1'b1;
        add_random_track(50, 1'b1);
        play_chunks(1'b0);

        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if ($urandom_range(0, 99) < 12) add_random_header();
            else if ($urandom_range(0, 99) < 70) add_random_track($urandom_range(1, 10), 1'b0);
            else add_random_track($urandom_range(10, 30), 1'b0);
            play_chunks($urandom_range(0, 99) < 75);
            if ($urandom_range(0, 99) < 10) wait_drained();
        end
        wait_drained();

        // unknown id: error item, then the parser ignores the rest
        do bad_id = $urandom; while (bad_id == ID_MTHD || bad_id == ID_MTRK);
        add_chunk(bad_id, 6);
        play_chunks(1'b1);

        wait_drained();
        repeat (8) @(negedge aclk);
        $display("Sent %0d file bytes: %0d header and %0d track chunks, ending on an unknown id.",
                 bytes_sent, header_chunks, track_chunks);
        $display("Checked %0d parser items under random idling and one long output stall.",
                 items_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/smfp_pkg.sv
src/smfp_in_reg.sv
src/smfp_parser.sv
src/smfp_out_reg.sv
src/midi_file_stream_parser_top.sv
dv/smf_event_checker.sv
dv/tb_midi_file_stream_parser_top.sv
